/* rtl/core/tfs_pkg.sv */
package tfs_pkg;

  localparam int unsigned TFS_QDEPTH = 2;

  localparam logic [15:0] Q15_ONE     = 16'd32768;
  localparam logic [15:0] Q15_MAX_POS = 16'sd32767;
  localparam logic [15:0] Q15_MAX_NEG = 16'h8000;

  localparam logic [15:0] FRESH_LIMIT_RST = 16'd250;
  localparam logic [14:0] FULL_LOCK_RST   = 15'd3000;
  localparam logic [15:0] STOP_BELOW_RST  = 16'd300;
  localparam logic [15:0] GO_ABOVE_RST    = 16'd500;
  localparam logic [15:0] CRUISE_RST      = 16'd6554;

  localparam logic [2:0] CFG_FRESH_LIMIT = 3'd0;
  localparam logic [2:0] CFG_FULL_LOCK   = 3'd1;
  localparam logic [2:0] CFG_STOP_BELOW  = 3'd2;
  localparam logic [2:0] CFG_GO_ABOVE    = 3'd3;
  localparam logic [2:0] CFG_CRUISE      = 3'd4;

  localparam logic [1:0] ST_LOST     = 2'd0;
  localparam logic [1:0] ST_NO_RANGE = 2'd1;
  localparam logic [1:0] ST_TRACKING = 2'd2;

  typedef struct packed {
    logic               lost;
    logic [15:0]        range_mm;
    logic signed [15:0] bearing_cdeg;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

/* rtl/core/tag_follow_steering_unit.sv */
// Flow: the beat ending a frame pushes its job into the queue; B_IDLE pops it, B_DIV runs
// 15 restoring divider steps, and B_DONE loads the result once the output is not stalled.
// Throughput: tag beats are taken one per cycle while the frame queue has room;
// the back end pops the next frame only after B_DONE has loaded the last result.
// Reset (rst_n low, synchronous): config registers take their defaults, the kept tag
// is cleared, the queue is emptied and the block starts blocked.
module tag_follow_steering_unit #(
  parameter int unsigned QUEUE_DEPTH = tfs_pkg::TFS_QDEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_tag_present,
  input  logic [15:0]        in_range_mm,
  input  logic signed [15:0] in_bearing_cdeg,
  input  logic [15:0]        in_frame_age_ms,
  input  logic               in_last_of_frame,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_throttle_q15,
  output logic signed [15:0] out_steer_q15,
  output logic [1:0]         out_track_status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import tfs_pkg::*;

  logic [15:0] fresh_limit_r;
  logic [14:0] full_lock_r;
  logic [15:0] stop_below_r;
  logic [15:0] go_above_r;
  logic [15:0] cruise_r;

  logic accept;
  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic q_avail;
  job_t head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_limit_r <= FRESH_LIMIT_RST;
      full_lock_r   <= FULL_LOCK_RST;
      stop_below_r  <= STOP_BELOW_RST;
      go_above_r    <= GO_ABOVE_RST;
      cruise_r      <= CRUISE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRESH_LIMIT: fresh_limit_r <= cfg_wdata;
        CFG_FULL_LOCK:   full_lock_r   <= cfg_wdata[14:0];
        CFG_STOP_BELOW:  stop_below_r  <= cfg_wdata;
        CFG_GO_ABOVE:    go_above_r    <= cfg_wdata;
        CFG_CRUISE:      cruise_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  tfs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .tag_present    (in_tag_present),
    .range_mm       (in_range_mm),
    .bearing_cdeg   (in_bearing_cdeg),
    .frame_age_ms   (in_frame_age_ms),
    .last_of_frame  (in_last_of_frame),
    .fresh_limit_ms (fresh_limit_r),
    .push           (push),
    .push_job       (push_job)
  );

  tfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .avail    (q_avail),
    .head_job (head_job)
  );

  tfs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_avail        (q_avail),
    .job              (head_job),
    .pop              (pop),
    .full_lock_cdeg   (full_lock_r),
    .stop_below_mm    (stop_below_r),
    .go_above_mm      (go_above_r),
    .cruise_q15       (cruise_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_throttle_q15 (out_throttle_q15),
    .out_steer_q15    (out_steer_q15),
    .out_track_status (out_track_status)
  );

endmodule

/* rtl/core/tfs_front.sv */
module tfs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               tag_present,
  input  logic [15:0]        range_mm,
  input  logic signed [15:0] bearing_cdeg,
  input  logic [15:0]        frame_age_ms,
  input  logic               last_of_frame,
  input  logic [15:0]        fresh_limit_ms,
  output logic               push,
  output tfs_pkg::job_t      push_job
);
  import tfs_pkg::*;

  logic               best_valid_r, best_valid_nxt;
  logic [15:0]        best_range_r, best_range_nxt;
  logic signed [15:0] best_bearing_r, best_bearing_nxt;
  logic               take;
  logic               eff_valid;
  logic [15:0]        eff_range;
  logic signed [15:0] eff_bearing;

  always_comb begin
    take = tag_present && (!best_valid_r ||
           (range_mm != 16'd0 && (best_range_r == 16'd0 || range_mm < best_range_r)));
    eff_valid   = best_valid_r || take;
    eff_range   = take ? range_mm : best_range_r;
    eff_bearing = take ? bearing_cdeg : best_bearing_r;

    push                  = accept && last_of_frame;
    push_job.lost         = !eff_valid || (frame_age_ms > fresh_limit_ms);
    push_job.range_mm     = eff_range;
    push_job.bearing_cdeg = eff_bearing;

    best_valid_nxt   = best_valid_r;
    best_range_nxt   = best_range_r;
    best_bearing_nxt = best_bearing_r;
    if (accept) begin
      if (last_of_frame) begin
        best_valid_nxt   = 1'b0;
        best_range_nxt   = 16'd0;
        best_bearing_nxt = 16'sd0;
      end else begin
        best_valid_nxt   = eff_valid;
        best_range_nxt   = eff_range;
        best_bearing_nxt = eff_bearing;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r   <= 1'b0;
      best_range_r   <= 16'd0;
      best_bearing_r <= 16'sd0;
    end else begin
      best_valid_r   <= best_valid_nxt;
      best_range_r   <= best_range_nxt;
      best_bearing_r <= best_bearing_nxt;
    end
  end

endmodule

/* rtl/core/tfs_queue.sv */
module tfs_queue #(
  parameter int unsigned DEPTH = tfs_pkg::TFS_QDEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tfs_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output tfs_pkg::job_t head_job
);
  import tfs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  always_comb begin
    full     = (cnt_r == FULL_CNT);
    avail    = (cnt_r != '0);
    head_job = slots_r[rd_ptr_r];
    do_push  = push && !full;
    do_pop   = pop && avail;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/tfs_back.sv */
module tfs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_avail,
  input  tfs_pkg::job_t       job,
  output logic                pop,
  input  logic [14:0]         full_lock_cdeg,
  input  logic [15:0]         stop_below_mm,
  input  logic [15:0]         go_above_mm,
  input  logic [15:0]         cruise_q15,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_throttle_q15,
  output logic signed [15:0]  out_steer_q15,
  output logic [1:0]          out_track_status
);
  import tfs_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [14:0]        quo_r, quo_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic               neg_r, neg_nxt;
  logic               lost_r, lost_nxt;
  logic [15:0]        range_r, range_nxt;
  logic               blocked_r, blocked_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               load_out;
  logic [15:0]        thr_r, thr_nxt;
  logic signed [15:0] steer_r, steer_nxt;
  logic [1:0]         status_r, status_nxt;

  logic [14:0] lock;
  logic [15:0] den;
  logic [15:0] mag;
  logic [31:0] num;
  logic [16:0] trial;
  logic        ge;
  logic [16:0] diff;
  logic [15:0] cruise_sat;

  always_comb begin
    lock  = (full_lock_cdeg == 15'd0) ? 15'd1 : full_lock_cdeg;
    den   = {lock, 1'b0};
    if (job.lost) begin
      mag = 16'd0;
    end else if (job.bearing_cdeg < 0) begin
      mag = 16'(-job.bearing_cdeg);
    end else begin
      mag = job.bearing_cdeg;
    end
    num   = {mag, 16'd0} + {17'd0, lock};
    trial = {rem_r, quo_r[14]};
    ge    = (trial >= {1'b0, den});
    diff  = trial - {1'b0, den};
    cruise_sat = (cruise_q15 > Q15_ONE) ? Q15_ONE : cruise_q15;

    state_nxt   = state_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    neg_nxt     = neg_r;
    lost_nxt    = lost_r;
    range_nxt   = range_r;
    blocked_nxt = blocked_r;
    thr_nxt     = thr_r;
    steer_nxt   = steer_r;
    status_nxt  = status_r;
    pop         = 1'b0;
    load_out    = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (job_avail) begin
          pop       = 1'b1;
          rem_nxt   = num[30:15];
          quo_nxt   = num[14:0];
          ovf_nxt   = (num >= {1'b0, den, 15'd0});
          neg_nxt   = job.bearing_cdeg < 0;
          lost_nxt  = job.lost;
          range_nxt = job.range_mm;
          cnt_nxt   = 4'd0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        rem_nxt = ge ? diff[15:0] : trial[15:0];
        quo_nxt = {quo_r[13:0], ge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd14) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = B_IDLE;
          thr_nxt   = 16'd0;
          if (neg_r) begin
            steer_nxt = ovf_r ? Q15_MAX_NEG : 16'(-$signed({1'b0, quo_r}));
          end else begin
            steer_nxt = ovf_r ? Q15_MAX_POS : {1'b0, quo_r};
          end
          if (lost_r) begin
            blocked_nxt = 1'b1;
            steer_nxt   = 16'sd0;
            status_nxt  = ST_LOST;
          end else if (range_r == 16'd0) begin
            blocked_nxt = 1'b1;
            status_nxt  = ST_NO_RANGE;
          end else begin
            if (range_r < stop_below_mm) begin
              blocked_nxt = 1'b1;
            end else if (range_r > go_above_mm) begin
              blocked_nxt = 1'b0;
            end
            if (!blocked_nxt) begin
              thr_nxt = cruise_sat;
            end
            status_nxt = ST_TRACKING;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      blocked_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      blocked_r   <= blocked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    ovf_r    <= ovf_nxt;
    neg_r    <= neg_nxt;
    lost_r   <= lost_nxt;
    range_r  <= range_nxt;
    thr_r    <= thr_nxt;
    steer_r  <= steer_nxt;
    status_r <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_throttle_q15 = thr_r;
  assign out_steer_q15    = steer_r;
  assign out_track_status = status_r;

endmodule

/* rtl/core/tfs_checker.sv */
module tfs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [15:0]        out_throttle_q15,
  input logic signed [15:0] out_steer_q15,
  input logic [1:0]         out_track_status
);
  import tfs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_throttle_q15) &&
      $stable(out_steer_q15) && $stable(out_track_status))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_track_status == ST_LOST || out_track_status == ST_NO_RANGE ||
      out_track_status == ST_TRACKING))
    else $error("bad track status");

  a_throttle_needs_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_throttle_q15 != 16'd0 |-> out_track_status == ST_TRACKING &&
      out_throttle_q15 <= Q15_ONE)
    else $error("throttle without tracking");

  a_lost_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_track_status == ST_LOST |-> out_steer_q15 == 16'sd0 &&
      out_throttle_q15 == 16'd0)
    else $error("lost frame gave nonzero proposal");

endmodule

bind tag_follow_steering_unit tfs_checker u_tfs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_throttle_q15 (out_throttle_q15),
  .out_steer_q15    (out_steer_q15),
  .out_track_status (out_track_status)
);
